// ===== design/lr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Beat payload structs, coordinate widths, controller/datapath links.
// ----------------------------------------------------------------------------
package lr_pkg;

   localparam int COORD_BITS = 6;
   localparam int FIELD_BITS = 6;
   localparam int D_BITS     = COORD_BITS + 2;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic signed [D_BITS-1:0] decision_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] start_x;
      logic [FIELD_BITS-1:0] start_y;
      logic [FIELD_BITS-1:0] end_x;
      logic [FIELD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel_x;
      logic [FIELD_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic at_end;
   } status_type;

endpackage

// ===== design/lr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_ctrl: line rasterizer controller
// Accepts a request, then steps the datapath once per free output slot.
// ----------------------------------------------------------------------------
module lr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  lr_pkg::status_type status,
   output lr_pkg::cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic emit;

   assign req_stall = (state_ff != ST_IDLE);
   assign emit      = (state_ff == ST_RUN) && (!rsp_valid_ff || !rsp_stall);
   assign cmd.load  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.step  = emit;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (emit && status.at_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/lr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_datapath: line rasterizer datapath
// Octant setup, midpoint decision step and the result beat register.
// ----------------------------------------------------------------------------
module lr_datapath (
   input  logic                clock,
   input  lr_pkg::req_type     req_data,
   output lr_pkg::rsp_type     rsp_data,
   input  lr_pkg::cmd_type     cmd,
   output lr_pkg::status_type  status
);

   lr_pkg::coord_type    raw_ax, raw_ay, raw_bx, raw_by;
   lr_pkg::coord_type    ax, ay, bx, by, dx, ady, major, minor;
   logic                 swap, dy_neg, steep;
   lr_pkg::decision_type d_init;

   lr_pkg::coord_type    x0_ff, y0_ff, major_ff, minor_ff, u_ff, v_ff;
   logic                 steep_ff, yneg_ff;
   lr_pkg::decision_type d_ff;
   lr_pkg::rsp_type      out_ff;

   lr_pkg::coord_type    px, py, ofs;
   lr_pkg::decision_type minor_ext, major_ext;
   logic                 hold_minor;

   // setup
   assign raw_ax = req_data.start_x[lr_pkg::COORD_BITS-1:0];
   assign raw_ay = req_data.start_y[lr_pkg::COORD_BITS-1:0];
   assign raw_bx = req_data.end_x[lr_pkg::COORD_BITS-1:0];
   assign raw_by = req_data.end_y[lr_pkg::COORD_BITS-1:0];

   assign swap   = raw_ax > raw_bx;
   assign ax     = swap ? raw_bx : raw_ax;
   assign ay     = swap ? raw_by : raw_ay;
   assign bx     = swap ? raw_ax : raw_bx;
   assign by     = swap ? raw_ay : raw_by;
   assign dx     = bx - ax;
   assign dy_neg = by < ay;
   assign ady    = dy_neg ? (ay - by) : (by - ay);
   assign steep  = ady > dx;
   assign major  = steep ? ady : dx;
   assign minor  = steep ? dx : ady;
   assign d_init = $signed({2'b00, minor}) - $signed({3'b000, major[lr_pkg::COORD_BITS-1:1]});

   // step
   assign minor_ext  = $signed({2'b00, minor_ff});
   assign major_ext  = $signed({2'b00, major_ff});
   assign hold_minor = d_ff[lr_pkg::D_BITS-1] || (d_ff == '0);

   assign px  = steep_ff ? (x0_ff + v_ff) : (x0_ff + u_ff);
   assign ofs = steep_ff ? u_ff : v_ff;
   assign py  = yneg_ff ? (y0_ff - ofs) : (y0_ff + ofs);

   assign status.at_end = (u_ff == major_ff);
   assign rsp_data      = out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff    <= ax;
         y0_ff    <= ay;
         steep_ff <= steep;
         yneg_ff  <= dy_neg;
         major_ff <= major;
         minor_ff <= minor;
         d_ff     <= d_init;
         u_ff     <= '0;
         v_ff     <= '0;
      end else if (cmd.step) begin
         u_ff <= u_ff + 1'b1;
         if (hold_minor) begin
            d_ff <= d_ff + minor_ext;
         end else begin
            v_ff <= v_ff + 1'b1;
            d_ff <= d_ff + minor_ext - major_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         out_ff.pixel_x    <= lr_pkg::FIELD_BITS'(px);
         out_ff.pixel_y    <= lr_pkg::FIELD_BITS'(py);
         out_ff.last_pixel <= status.at_end;
      end
   end

endmodule

// ===== design/line_rasterizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_top: midpoint line rasterizer for a 64 by 64 tile
// One request beat gives two endpoints; one response beat per pixel follows,
// from the endpoint with the smaller x to the far endpoint, last_pixel set on
// the final one. Accepting a request sets up the octant; then one pixel per
// cycle follows from the single decision-value step unit while the response
// side does not stall. The next request is taken in the cycle after the last
// pixel enters the response register.
// ----------------------------------------------------------------------------
module line_rasterizer_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output lr_pkg::rsp_type rsp_data
);

   lr_pkg::cmd_type    cmd;
   lr_pkg::status_type status;

   lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lr_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule
